// File: hw/rtl/sha256_message_digest_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 digest assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define SMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/smd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest package
// Round constants, initial hash value, round functions and shared types.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // One block word on its way from the front to the compression engine.
  typedef struct packed {
    logic [31:0] data;
    logic        last_blk;   // final word of the final block of a message
  } blk_word_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD,
    F_FILL,
    F_LEN_LO
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_ADD,
    B_OUT
  } back_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: hw/rtl/smd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest channels
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface smd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface smd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_end;

  modport source (output valid, digest_word, word_index, digest_end, input ready);
  modport sink   (input valid, digest_word, word_index, digest_end, output ready);
endinterface

// File: hw/rtl/smd_front.sv
`timescale 1ns / 1ps
`include "sha256_message_digest_defines.svh"
// ----------------------------------------------------------------------------
// SHA-256 digest front end
// Takes message words, counts the bit length and emits the block word stream
// including pad byte, zero fill and the 64-bit length.
// ----------------------------------------------------------------------------
module smd_front (
  input  logic                clk,
  input  logic                rst_n,
  smd_in_if.sink              in_word,
  output logic                push_valid,
  input  logic                push_ready,
  output smd_pkg::blk_word_t  push_data
);
  import smd_pkg::*;

  front_state_t state_r, state_nxt;
  logic [3:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [2:0]   nbytes_sat;
  logic [5:0]   add_bits;
  logic         accept;

  assign nbytes_sat = (in_word.valid_bytes > 3'd4) ? 3'd4 : in_word.valid_bytes;
  assign add_bits   = in_word.last_word ? {nbytes_sat, 3'b000} : 6'd32;
  assign in_word.ready = (state_r == F_IDLE) && push_ready;
  assign accept     = in_word.valid && in_word.ready;

  always_comb begin
    state_nxt           = state_r;
    fill_nxt            = fill_r;
    len_nxt             = len_r;
    push_valid          = 1'b0;
    push_data.data      = in_word.message_word;
    push_data.last_blk  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        push_valid = in_word.valid;
        if (in_word.last_word) begin
          // fold the pad byte into a partial last word
          unique case (nbytes_sat)
            3'd0:    push_data.data = PAD_WORD;
            3'd1:    push_data.data = {in_word.message_word[31:24], 8'h80, 16'h0000};
            3'd2:    push_data.data = {in_word.message_word[31:16], 8'h80, 8'h00};
            3'd3:    push_data.data = {in_word.message_word[31:8], 8'h80};
            default: push_data.data = in_word.message_word;
          endcase
        end
        if (accept) begin
          fill_nxt = fill_r + 4'd1;
          len_nxt  = len_r + {58'd0, add_bits};
          if (in_word.last_word) begin
            state_nxt = (nbytes_sat == 3'd4) ? F_PAD : F_FILL;
          end
        end
      end
      F_PAD: begin
        push_valid     = 1'b1;
        push_data.data = PAD_WORD;
        if (push_ready) begin
          fill_nxt  = fill_r + 4'd1;
          state_nxt = F_FILL;
        end
      end
      F_FILL: begin
        // zero fill up to word 14, wrapping into an extra block if needed
        push_valid     = 1'b1;
        push_data.data = (fill_r == 4'd14) ? len_r[63:32] : 32'd0;
        if (push_ready) begin
          fill_nxt = fill_r + 4'd1;
          if (fill_r == 4'd14) begin
            state_nxt = F_LEN_LO;
          end
        end
      end
      F_LEN_LO: begin
        push_valid         = 1'b1;
        push_data.data     = len_r[31:0];
        push_data.last_blk = 1'b1;
        if (push_ready) begin
          fill_nxt  = 4'd0;
          len_nxt   = 64'd0;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fill_r  <= 4'd0;
      len_r   <= 64'd0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
    end
  end

  `SMD_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != F_IDLE, !in_word.ready, "front ready while padding")
  `SMD_ASSERT_NXT(a_last_starts_pad, clk, rst_n, accept && in_word.last_word, state_r != F_IDLE, "last word did not start padding")
  `SMD_ASSERT_IMP(a_len_lo_at_end, clk, rst_n, state_r == F_LEN_LO, fill_r == 4'd15, "length low word not at block end")

endmodule

// File: hw/rtl/smd_queue.sv
`timescale 1ns / 1ps
`include "sha256_message_digest_defines.svh"
// ----------------------------------------------------------------------------
// SHA-256 digest word queue
// Short FIFO of block words between the front end and the compression engine.
// ----------------------------------------------------------------------------
module smd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  smd_pkg::blk_word_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output smd_pkg::blk_word_t  pop_data
);
  import smd_pkg::*;

  blk_word_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `SMD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `SMD_ASSERT_NXT(a_count_up, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count missed a push")
  `SMD_ASSERT_NXT(a_count_down, clk, rst_n, do_pop && !do_push, count_r == $past(count_r) - 1'b1, "queue count missed a pop")

endmodule

// File: hw/rtl/smd_back.sv
`timescale 1ns / 1ps
`include "sha256_message_digest_defines.svh"
// ----------------------------------------------------------------------------
// SHA-256 digest compression engine
// Loads 16 block words, runs 64 rounds one per cycle, adds into the hash and
// sends out the eight digest words after the final block.
// ----------------------------------------------------------------------------
module smd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  smd_pkg::blk_word_t  pop_data,
  smd_out_if.source           out_digest
);
  import smd_pkg::*;

  back_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        last_r, last_nxt;
  logic [31:0] w_r    [16];
  logic [31:0] w_nxt  [16];
  logic [31:0] v_r    [8];
  logic [31:0] v_nxt  [8];
  logic [31:0] hash_r   [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] w_new, t1, t2, ch, maj;

  // message schedule extension and round sums
  assign w_new = small_sig1(w_r[14]) + w_r[9] + small_sig0(w_r[1]) + w_r[0];
  assign ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1    = v_r[7] + big_sig1(v_r[4]) + ch + ROUND_K[cnt_r] + w_r[0];
  assign t2    = big_sig0(v_r[0]) + maj;

  assign out_digest.valid       = (state_r == B_OUT);
  assign out_digest.digest_word = hash_r[idx_r];
  assign out_digest.word_index  = idx_r;
  assign out_digest.digest_end  = (idx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    w_nxt     = w_r;
    v_nxt     = v_r;
    hash_nxt  = hash_r;
    pop_ready = 1'b0;
    unique case (state_r)
      B_LOAD: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[15] = pop_data.data;
          cnt_nxt   = cnt_r + 6'd1;
          if (cnt_r == 6'd15) begin
            cnt_nxt   = 6'd0;
            last_nxt  = pop_data.last_blk;
            v_nxt     = hash_r;
            state_nxt = B_ROUND;
          end
        end
      end
      B_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        for (int i = 1; i < 8; i++) begin
          v_nxt[i] = v_r[i-1];
        end
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          cnt_nxt   = 6'd0;
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        idx_nxt   = 3'd0;
        state_nxt = last_r ? B_OUT : B_LOAD;
      end
      B_OUT: begin
        if (out_digest.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            // start over for the next message
            hash_nxt  = H_INIT;
            last_nxt  = 1'b0;
            state_nxt = B_LOAD;
          end
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      cnt_r   <= 6'd0;
      idx_r   <= 3'd0;
      last_r  <= 1'b0;
      hash_r  <= H_INIT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      hash_r  <= hash_nxt;
    end
  end

  `SMD_ASSERT_NXT(a_load_to_round, clk, rst_n, state_r == B_LOAD && pop_valid && cnt_r == 6'd15, state_r == B_ROUND && cnt_r == 6'd0, "block load did not start rounds")
  `SMD_ASSERT_NXT(a_round_to_add, clk, rst_n, state_r == B_ROUND && cnt_r == 6'd63, state_r == B_ADD, "rounds did not end after 64")
  `SMD_ASSERT_NXT(a_hash_restart, clk, rst_n, out_digest.valid && out_digest.ready && idx_r == 3'd7, hash_r[0] == H_INIT[0] && state_r == B_LOAD, "hash not restarted after digest")

endmodule

// File: hw/rtl/sha256_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Hashes a message given as big-endian 32-bit words and returns the digest.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries the message, one word per handshake, first byte in bits
//   31..24. Only the word marked last_word may hold fewer than four bytes
//   (valid_bytes 0..4; values above four count as four; zero closes an empty
//   message or one that ends on a word boundary).
//   out_digest returns eight digest words, word_index 0..7, digest_end on the
//   eighth, one word per cycle while the receiver is ready.
//   Each 16-word block goes through the compression engine as a load of its
//   16 words, 64 rounds on a single round unit and an add into the hash; a
//   4-entry queue lets the front take words while a block compresses.
//   Padding completes the last block and adds one more block when fewer
//   than two words are free in it after the pad; the first digest word
//   shows in the cycle after the final block's add.
//   A stalled receiver holds the digest word and its index; the front keeps
//   taking the next message's words until the queue fills.
//   Reset (rst_n low, synchronous) drops any partial message and restores
//   the initial hash value.
// ----------------------------------------------------------------------------
module sha256_message_digest (
  input  logic       clk,
  input  logic       rst_n,
  smd_in_if.sink     in_word,
  smd_out_if.source  out_digest
);
  import smd_pkg::*;

  logic      push_valid, push_ready;
  blk_word_t push_data;
  logic      pop_valid, pop_ready;
  blk_word_t pop_data;

  smd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  smd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  smd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_digest (out_digest)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Sends directed and random messages through the word channel. A scoreboard
// hashes each message as its words are taken and checks the eight digest words
// that come back. Both channels stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import smd_pkg::*;

  localparam int unsigned IDLE_PCT       = 24;
  localparam int unsigned RANDOM_WORDS   = 90;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_t;

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int unsigned held;
    logic [63:0] msg_bits;
    digest_t     due [$];
    int unsigned errors;
    int unsigned messages;
    int unsigned words_in;
    int unsigned checked;

    function new();
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = H_INIT[i];
      held     = 0;
      msg_bits = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the current block and fold into the chain.
    function void absorb();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w[t] = blk[t];
        end else begin
          s0   = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
          s1   = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
          w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[t] + w[t];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void take(logic [31:0] w);
      blk[held] = w;
      held++;
      if (held == 16) begin
        absorb();
        held = 0;
      end
    endfunction

    function void note_word(logic [31:0] w, logic [2:0] vb, logic lw);
      logic [31:0] tail;
      int unsigned n;
      digest_t     d;
      words_in++;
      // A word that is not last always counts as four bytes.
      if (!lw) begin
        take(w);
        msg_bits += 32;
        return;
      end
      n = (vb > 4) ? 4 : vb;
      if (n == 4) begin
        take(w);
        msg_bits += 32;
        tail = PAD_WORD;
      end else if (n == 0) begin
        tail = PAD_WORD;
      end else begin
        // Keep the leading bytes, replace the rest by the pad byte and zeros.
        tail = (w & (32'hFFFF_FFFF << (32 - 8 * n))) | (PAD_WORD >> (8 * n));
        msg_bits += 8 * n;
      end
      take(tail);
      // No room left for the length: close this block and open another.
      if (held > 14) begin
        while (held != 0) take('0);
      end
      while (held < 14) take('0);
      take(msg_bits[63:32]);
      take(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        d.word = chain[k];
        d.idx  = 3'(k);
        d.fin  = (k == 7);
        due.push_back(d);
      end
      messages++;
      restart();
    endfunction

    function void check_digest(logic [31:0] w, logic [2:0] idx, logic fin);
      digest_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: digest word %h (index %0d) with nothing pending", $time, w, idx);
        return;
      end
      want = due.pop_front();
      checked++;
      if (w !== want.word) begin
        errors++;
        $display("%0t: digest_word expected %h, got %h", $time, want.word, w);
      end
      if (idx !== want.idx) begin
        errors++;
        $display("%0t: word_index expected %0d, got %0d", $time, want.idx, idx);
      end
      if (fin !== want.fin) begin
        errors++;
        $display("%0t: digest_end expected %b, got %b", $time, want.fin, fin);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  bit   in_took;
  bit   out_took;
  int unsigned quiet;

  digest_scoreboard sb = new();

  smd_in_if  in_bus ();
  smd_out_if out_bus ();

  sha256_message_digest uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_bus),
    .out_digest (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Sample both channels mid-cycle; a word seen here is taken at the next edge.
  always @(negedge clk) begin
    in_took  = rst_n && in_bus.valid && in_bus.ready;
    out_took = rst_n && out_bus.valid && out_bus.ready;
    if (in_took) sb.note_word(in_bus.message_word, in_bus.valid_bytes, in_bus.last_word);
    if (out_took) sb.check_digest(out_bus.digest_word, out_bus.word_index,
                                  out_bus.digest_end);
    if (!rst_n || in_took || out_took) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] vb, input logic lw);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid        <= 1'b1;
    in_bus.message_word <= w;
    in_bus.valid_bytes  <= vb;
    in_bus.last_word    <= lw;
    @(posedge clk);
    while (!in_took) @(posedge clk);
  endtask

  task automatic send_message(input int unsigned body);
    for (int i = 0; i < body; i++) send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin
    int unsigned body;
    int unsigned sent;
    sent                 = 0;
    rst_n               <= 1'b0;
    steady              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.message_word <= '0;
    in_bus.valid_bytes  <= '0;
    in_bus.last_word    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, then short tails with valid_bytes of two to seven.
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h6162_63FF, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_word(32'hA5A5_A5A5, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
    send_word(32'h0000_0000, 3'd6, 1'b1);
    send_word(32'h5A5A_5A5A, 3'd7, 1'b1);
    // Byte count on a word that is not last must be ignored.
    send_word(32'h1234_5678, 3'd1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    // Fourteen full words leave no room for the length: extra block.
    for (int i = 0; i < 13; i++) send_word(i[0] ? 32'hFFFF_FFFF : 32'h0, 3'd0, 1'b0);
    send_word(32'h8000_0001, 3'd4, 1'b1);

    while (sent < RANDOM_WORDS) begin
      steady <= (sent >= 40 && sent < 80);
      case ($urandom_range(0, 3))
        0:       body = $urandom_range(0, 3);
        1:       body = $urandom_range(12, 17);
        2:       body = $urandom_range(18, 40);
        default: body = $urandom_range(4, 11);
      endcase
      send_message(body);
      sent += body + 1;
    end
    in_bus.valid <= 1'b0;
    steady       <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d words, tails of 0 to 7 bytes and padding blocks.",
             sb.messages, sb.words_in);
    $display("Checked %0d digest words under random stalls on both sides, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/smd_pkg.sv
hw/rtl/smd_if.sv
hw/rtl/smd_front.sv
hw/rtl/smd_queue.sv
hw/rtl/smd_back.sv
hw/rtl/sha256_message_digest.sv
bench/tb_top.sv
